[rtl/psc_pkg.sv]
// Shared widths, constants and register indices for the pressure compensation pipeline.
`default_nettype none

package psc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_C1      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_C2      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_C3      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_C4      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_C5      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_C6      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SURFACE = 3'd6;

    localparam logic [14:0] SURFACE_RESET = 15'd1013;

    // pipeline depth: one valid bit per stage
    localparam int NUM_STAGES = 13;

    // internal widths, sized to the value ranges
    localparam int DT_W    = 25;   // dT
    localparam int PTC_W   = 42;   // dT * Cx products
    localparam int DT2_W   = 49;   // dT squared (never negative)
    localparam int DEV_W   = 18;   // TEMP - 2000
    localparam int OFF_W   = 35;
    localparam int SENS_W  = 34;
    localparam int T2_W    = 18;
    localparam int AUX_W   = 35;   // (TEMP - 2000) squared
    localparam int XT_W    = 20;   // TEMP - T2
    localparam int OFFA_W  = 37;   // OFF - OFF2
    localparam int SENSA_W = 36;   // SENS - SENS2
    localparam int SPLIT   = 18;   // partial product split point of SENS
    localparam int PLO_W   = 42;
    localparam int PHI_W   = 43;
    localparam int PROD_W  = 61;   // D1 * SENS
    localparam int X1_W    = 40;
    localparam int Q1_W    = 41;
    localparam int Q_W     = 19;
    localparam int TPROD_W = 28;
    localparam int QP_W    = 38;

    localparam logic signed [XT_W-1:0] REF_TEMP    = XT_W'(2000);
    localparam logic signed [XT_W-1:0] TEMP_HI_LIM = XT_W'(8500);
    localparam logic signed [XT_W-1:0] TEMP_LO_LIM = XT_W'(-4000);
    localparam logic signed [7:0]      TC_MAX      = 8'sd85;
    localparam logic signed [7:0]      TC_MIN      = -8'sd40;

    localparam logic [14:0]            P_MAX       = 15'd30000;
    localparam logic signed [Q1_W-1:0] Q_MAX       = Q1_W'(300009);

    // reciprocals: floor(x * R >> s) equals x / d over the ranges used
    localparam logic [13:0] DIV100_RECIP = 14'd10486;   // shift 20, x < 8500
    localparam logic [18:0] DIV10_RECIP  = 19'd419431;  // shift 22, x < 2^19

    // 0.983615 in Q16, rounded to nearest
    localparam logic [15:0] DEPTH_Q16 = 16'd64462;

endpackage

`default_nettype wire

[rtl/pressure_sensor_compensation.sv]
// Top level: thirteen-stage pipeline for second-order barometric compensation.
// Results: an item taken at a clock edge moves through each stage register in turn and
//   reaches the outputs, with done high, after the last stage.
// Throughput: one item per cycle; busy stays low since nothing downstream can stall.
// The rate is set by the pipeline registers around each multiplier (dT products,
//   dev squared, the split D1 * SENS product, the two reciprocal divides and depth scaling).
// Reset: rst_n clears the stage valid bits, C1..C6 to zero, surface pressure to 1013.
`default_nettype none

module pressure_sensor_compensation
    import psc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // item in
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [23:0]           d1_raw,
    input  wire logic [23:0]           d2_raw,
    // result out
    output logic                       done,
    output logic signed [7:0]          temperature_c,
    output logic [14:0]                pressure_mbar,
    output logic [14:0]                depth,
    // configuration
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [15:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;
    logic [14:0] surface_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg      <= '0;
            c2_reg      <= '0;
            c3_reg      <= '0;
            c4_reg      <= '0;
            c5_reg      <= '0;
            c6_reg      <= '0;
            surface_reg <= SURFACE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_C1:      c1_reg      <= wr_data;
                REG_C2:      c2_reg      <= wr_data;
                REG_C3:      c3_reg      <= wr_data;
                REG_C4:      c4_reg      <= wr_data;
                REG_C5:      c5_reg      <= wr_data;
                REG_C6:      c6_reg      <= wr_data;
                REG_SURFACE: surface_reg <= wr_data[14:0];
                default:     ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits, one per stage. Nothing ever stalls, so they just shift.
    // ------------------------------------------------------------------
    logic                  accept;
    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES:1]   vld_next;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[NUM_STAGES-1:1], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Delay lines for values that ride along unchanged
    logic [23:0]              d1_pipe_reg   [1:5];
    logic signed [OFFA_W-1:0] offa_pipe_reg [5:8];
    logic signed [7:0]        tc_pipe_reg   [6:13];

    // ------------------------------------------------------------------
    // Stage 1: dT = D2 - C5 * 256
    // ------------------------------------------------------------------
    logic signed [DT_W-1:0] s1_dt_reg, s1_dt_next;

    assign s1_dt_next = $signed({1'b0, d2_raw}) - $signed({1'b0, c5_reg, 8'h00});

    // ------------------------------------------------------------------
    // Stage 2: the four dT products, in parallel
    // ------------------------------------------------------------------
    logic signed [PTC_W-1:0]  s2_tc6_reg, s2_tc6_next;
    logic signed [PTC_W-1:0]  s2_c4p_reg, s2_c4p_next;
    logic signed [PTC_W-1:0]  s2_c3p_reg, s2_c3p_next;
    logic signed [2*DT_W-1:0] dt2_full;
    logic [DT2_W-1:0]         s2_dt2_reg, s2_dt2_next;

    assign s2_tc6_next = s1_dt_reg * $signed({1'b0, c6_reg});
    assign s2_c4p_next = s1_dt_reg * $signed({1'b0, c4_reg});
    assign s2_c3p_next = s1_dt_reg * $signed({1'b0, c3_reg});
    assign dt2_full    = s1_dt_reg * s1_dt_reg;
    assign s2_dt2_next = dt2_full[DT2_W-1:0];

    // ------------------------------------------------------------------
    // Stage 3: TEMP deviation, OFF, SENS, branch select and T2.
    // Signed divides by powers of two round toward zero: bias negatives first.
    // ------------------------------------------------------------------
    logic signed [PTC_W-1:0] tc6_biased, tc6_sh;
    logic signed [PTC_W-1:0] c4_biased, c4_sh;
    logic signed [PTC_W-1:0] c3_biased, c3_sh;
    logic [DT2_W+1:0]        dt2_x3;
    logic [T2_W-1:0]         t2_low, t2_high;

    logic signed [DEV_W-1:0]  s3_dev_reg, s3_dev_next;
    logic                     s3_low_reg, s3_low_next;
    logic signed [OFF_W-1:0]  s3_off_reg, s3_off_next;
    logic signed [SENS_W-1:0] s3_sens_reg, s3_sens_next;
    logic [T2_W-1:0]          s3_t2_reg, s3_t2_next;

    assign tc6_biased = s2_tc6_reg
                      + $signed({{(PTC_W-23){1'b0}}, {23{s2_tc6_reg[PTC_W-1]}}});
    assign tc6_sh     = tc6_biased >>> 23;
    assign c4_biased  = s2_c4p_reg
                      + $signed({{(PTC_W-7){1'b0}}, {7{s2_c4p_reg[PTC_W-1]}}});
    assign c4_sh      = c4_biased >>> 7;
    assign c3_biased  = s2_c3p_reg
                      + $signed({{(PTC_W-8){1'b0}}, {8{s2_c3p_reg[PTC_W-1]}}});
    assign c3_sh      = c3_biased >>> 8;

    assign s3_dev_next  = tc6_sh[DEV_W-1:0];
    assign s3_low_next  = s3_dev_next[DEV_W-1];   // TEMP below 20.00 C
    assign s3_off_next  = $signed({3'b000, c2_reg, 16'h0000}) + c4_sh[OFF_W-1:0];
    assign s3_sens_next = $signed({3'b000, c1_reg, 15'h0000}) + c3_sh[SENS_W-1:0];

    // low branch: 3 * dT^2 / 2^33, high branch: 2 * dT^2 / 2^37
    assign dt2_x3     = {2'b00, s2_dt2_reg} + {1'b0, s2_dt2_reg, 1'b0};
    assign t2_low     = dt2_x3[DT2_W+1:33];
    assign t2_high    = {5'b00000, s2_dt2_reg[DT2_W-1:36]};
    assign s3_t2_next = s3_low_next ? t2_low : t2_high;

    // ------------------------------------------------------------------
    // Stage 4: A = dev^2, TEMP - T2
    // ------------------------------------------------------------------
    logic signed [2*DEV_W-1:0] aux_full;
    logic [AUX_W-1:0]          s4_aux_reg, s4_aux_next;
    logic signed [XT_W-1:0]    s4_xt_reg, s4_xt_next;
    logic                      s4_low_reg;
    logic signed [OFF_W-1:0]   s4_off_reg;
    logic signed [SENS_W-1:0]  s4_sens_reg;

    assign aux_full    = s3_dev_reg * s3_dev_reg;
    assign s4_aux_next = aux_full[AUX_W-1:0];
    assign s4_xt_next  = $signed({{(XT_W-DEV_W){s3_dev_reg[DEV_W-1]}}, s3_dev_reg})
                       + REF_TEMP
                       - $signed({{(XT_W-T2_W){1'b0}}, s3_t2_reg});

    // ------------------------------------------------------------------
    // Stage 5: OFF2 / SENS2 correction; temperature divide by 100
    // ------------------------------------------------------------------
    logic [AUX_W+1:0]         aux_x3;
    logic [AUX_W+2:0]         aux_x5;
    logic [AUX_W:0]           off2;
    logic [AUX_W-1:0]         sens2;
    logic                     t_hi, t_lo, t_neg;
    logic signed [XT_W-1:0]   xt_abs;

    logic signed [SENSA_W-1:0] s5_sensa_reg, s5_sensa_next;
    logic signed [OFFA_W-1:0]  offa_next;
    logic [TPROD_W-1:0]        s5_tprod_reg, s5_tprod_next;
    logic                      s5_thi_reg, s5_tlo_reg, s5_tneg_reg;

    assign aux_x3 = {2'b00, s4_aux_reg} + {1'b0, s4_aux_reg, 1'b0};
    assign aux_x5 = {3'b000, s4_aux_reg} + {1'b0, s4_aux_reg, 2'b00};
    assign off2   = s4_low_reg ? aux_x3[AUX_W+1:1]
                               : {5'b00000, s4_aux_reg[AUX_W-1:4]};
    assign sens2  = s4_low_reg ? aux_x5[AUX_W+2:3] : '0;

    assign offa_next     = $signed({{(OFFA_W-OFF_W){s4_off_reg[OFF_W-1]}}, s4_off_reg})
                         - $signed({1'b0, off2});
    assign s5_sensa_next = $signed({{(SENSA_W-SENS_W){s4_sens_reg[SENS_W-1]}},
                                    s4_sens_reg})
                         - $signed({1'b0, sens2});

    // saturation decided on TEMP - T2 itself, divide only the in-range magnitude
    assign t_hi   = (s4_xt_reg >= TEMP_HI_LIM);
    assign t_lo   = (s4_xt_reg <= TEMP_LO_LIM);
    assign t_neg  = s4_xt_reg[XT_W-1];
    assign xt_abs = t_neg ? -s4_xt_reg : s4_xt_reg;
    assign s5_tprod_next = xt_abs[13:0] * DIV100_RECIP;

    // ------------------------------------------------------------------
    // Stage 6: D1 * SENS as two partial products; final temperature
    // ------------------------------------------------------------------
    logic [PLO_W-1:0]        s6_pplo_reg, s6_pplo_next;
    logic signed [PHI_W-1:0] s6_pphi_reg, s6_pphi_next;
    logic [7:0]              tq;
    logic signed [7:0]       tc_next;

    assign s6_pplo_next = d1_pipe_reg[5] * s5_sensa_reg[SPLIT-1:0];
    assign s6_pphi_next = $signed({1'b0, d1_pipe_reg[5]})
                        * $signed(s5_sensa_reg[SENSA_W-1:SPLIT]);

    assign tq = s5_tprod_reg[TPROD_W-1:20];

    always_comb
    begin
        priority if (s5_thi_reg)
            tc_next = TC_MAX;
        else if (s5_tlo_reg)
            tc_next = TC_MIN;
        else if (s5_tneg_reg)
            tc_next = -$signed(tq);
        else
            tc_next = $signed(tq);
    end

    // ------------------------------------------------------------------
    // Stage 7: recombine the partial products
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] s7_prod_reg, s7_prod_next;

    assign s7_prod_next = $signed({s6_pphi_reg, {SPLIT{1'b0}}})
                        + $signed({{(PROD_W-PLO_W){1'b0}}, s6_pplo_reg});

    // ------------------------------------------------------------------
    // Stage 8: divide by 2^21, toward zero
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_biased, prod_sh;
    logic signed [X1_W-1:0]   s8_x1_reg, s8_x1_next;

    assign prod_biased = s7_prod_reg
                       + $signed({{(PROD_W-21){1'b0}}, {21{s7_prod_reg[PROD_W-1]}}});
    assign prod_sh     = prod_biased >>> 21;
    assign s8_x1_next  = prod_sh[X1_W-1:0];

    // ------------------------------------------------------------------
    // Stage 9: subtract corrected OFF
    // ------------------------------------------------------------------
    logic signed [Q1_W-1:0] s9_q1_reg, s9_q1_next;

    assign s9_q1_next = $signed({s8_x1_reg[X1_W-1], s8_x1_reg})
                      - $signed({{(Q1_W-OFFA_W){offa_pipe_reg[8][OFFA_W-1]}},
                                 offa_pipe_reg[8]});

    // ------------------------------------------------------------------
    // Stage 10: divide by 2^13 and classify. A negative value ends as zero
    // pressure whichever way it rounds, so a plain arithmetic shift will do.
    // ------------------------------------------------------------------
    logic signed [Q1_W-1:0] q_sh;
    logic [Q_W-1:0]         s10_q_reg, s10_q_next;
    logic                   s10_qneg_reg, s10_qneg_next;
    logic                   s10_qbig_reg, s10_qbig_next;

    assign q_sh          = s9_q1_reg >>> 13;
    assign s10_qneg_next = s9_q1_reg[Q1_W-1];
    assign s10_qbig_next = !s10_qneg_next && (q_sh > Q_MAX);
    assign s10_q_next    = q_sh[Q_W-1:0];

    // ------------------------------------------------------------------
    // Stage 11: divide by 10 through the reciprocal
    // ------------------------------------------------------------------
    logic [QP_W-1:0] s11_qp_reg, s11_qp_next;
    logic            s11_qneg_reg, s11_qbig_reg;

    assign s11_qp_next = s10_q_reg * DIV10_RECIP;

    // ------------------------------------------------------------------
    // Stage 12: saturated pressure and difference to the surface baseline
    // ------------------------------------------------------------------
    logic [15:0]        p_div;
    logic signed [15:0] diff;
    logic [14:0]        s12_p_reg, s12_p_next;
    logic [14:0]        s12_diff_reg, s12_diff_next;
    logic               s12_dpos_reg, s12_dpos_next;

    assign p_div = s11_qp_reg[QP_W-1:22];

    always_comb
    begin
        priority if (s11_qneg_reg)
            s12_p_next = '0;
        else if (s11_qbig_reg)
            s12_p_next = P_MAX;
        else
            s12_p_next = p_div[14:0];
    end

    assign diff          = $signed({1'b0, s12_p_next}) - $signed({1'b0, surface_reg});
    assign s12_dpos_next = !diff[15] && (diff != 16'sd0);
    assign s12_diff_next = diff[14:0];

    // ------------------------------------------------------------------
    // Stage 13: depth = diff * 0.983615, zero at or below the baseline
    // ------------------------------------------------------------------
    logic [30:0] dprod;
    logic [14:0] s13_p_reg;
    logic [14:0] s13_depth_reg, s13_depth_next;

    assign dprod          = s12_diff_reg * DEPTH_Q16;
    assign s13_depth_next = s12_dpos_reg ? dprod[30:16] : '0;

    // ------------------------------------------------------------------
    // Payload registers: no reset, loaded every cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        s1_dt_reg      <= s1_dt_next;
        d1_pipe_reg[1] <= d1_raw;

        s2_tc6_reg     <= s2_tc6_next;
        s2_c4p_reg     <= s2_c4p_next;
        s2_c3p_reg     <= s2_c3p_next;
        s2_dt2_reg     <= s2_dt2_next;
        d1_pipe_reg[2] <= d1_pipe_reg[1];

        s3_dev_reg     <= s3_dev_next;
        s3_low_reg     <= s3_low_next;
        s3_off_reg     <= s3_off_next;
        s3_sens_reg    <= s3_sens_next;
        s3_t2_reg      <= s3_t2_next;
        d1_pipe_reg[3] <= d1_pipe_reg[2];

        s4_aux_reg     <= s4_aux_next;
        s4_xt_reg      <= s4_xt_next;
        s4_low_reg     <= s3_low_reg;
        s4_off_reg     <= s3_off_reg;
        s4_sens_reg    <= s3_sens_reg;
        d1_pipe_reg[4] <= d1_pipe_reg[3];

        s5_sensa_reg     <= s5_sensa_next;
        offa_pipe_reg[5] <= offa_next;
        s5_tprod_reg     <= s5_tprod_next;
        s5_thi_reg       <= t_hi;
        s5_tlo_reg       <= t_lo;
        s5_tneg_reg      <= t_neg;
        d1_pipe_reg[5]   <= d1_pipe_reg[4];

        s6_pplo_reg      <= s6_pplo_next;
        s6_pphi_reg      <= s6_pphi_next;
        offa_pipe_reg[6] <= offa_pipe_reg[5];
        tc_pipe_reg[6]   <= tc_next;

        s7_prod_reg      <= s7_prod_next;
        offa_pipe_reg[7] <= offa_pipe_reg[6];
        tc_pipe_reg[7]   <= tc_pipe_reg[6];

        s8_x1_reg        <= s8_x1_next;
        offa_pipe_reg[8] <= offa_pipe_reg[7];
        tc_pipe_reg[8]   <= tc_pipe_reg[7];

        s9_q1_reg        <= s9_q1_next;
        tc_pipe_reg[9]   <= tc_pipe_reg[8];

        s10_q_reg        <= s10_q_next;
        s10_qneg_reg     <= s10_qneg_next;
        s10_qbig_reg     <= s10_qbig_next;
        tc_pipe_reg[10]  <= tc_pipe_reg[9];

        s11_qp_reg       <= s11_qp_next;
        s11_qneg_reg     <= s10_qneg_reg;
        s11_qbig_reg     <= s10_qbig_reg;
        tc_pipe_reg[11]  <= tc_pipe_reg[10];

        s12_p_reg        <= s12_p_next;
        s12_diff_reg     <= s12_diff_next;
        s12_dpos_reg     <= s12_dpos_next;
        tc_pipe_reg[12]  <= tc_pipe_reg[11];

        s13_p_reg        <= s12_p_reg;
        s13_depth_reg    <= s13_depth_next;
        tc_pipe_reg[13]  <= tc_pipe_reg[12];
    end

    // ------------------------------------------------------------------
    // Outputs: one-cycle strobe with the last stage's payload
    // ------------------------------------------------------------------
    assign done          = vld_reg[NUM_STAGES];
    assign temperature_c = tc_pipe_reg[13];
    assign pressure_mbar = s13_p_reg;
    assign depth         = s13_depth_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(NUM_STAGES) done)
        else $error("item taken but no result after the pipeline latency");

    a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pressure_mbar <= P_MAX))
        else $error("pressure beyond saturation limit");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((temperature_c >= TC_MIN) && (temperature_c <= TC_MAX)))
        else $error("temperature beyond saturation limits");

    a_depth_below_press: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (depth != 15'd0)) |-> (depth < pressure_mbar))
        else $error("depth not below pressure");

endmodule

`default_nettype wire
